// File: rtl/core/cf2sa_pkg.sv
// Package for the CAN frame to SLCAN line encoder.
// Holds the word types, ASCII constants, the hex digit function and the microcode table.
// No dependencies.
package cf2sa_pkg;

  localparam int MAX_DATA = 8;
  localparam int NUM_STEPS = 8;

  typedef logic [2:0] step_t;
  typedef logic [3:0] len_t;

  localparam logic [7:0] CHAR_T  = 8'h74;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_A  = 8'h41;

  localparam len_t LEN_MAX = 4'd8;

  localparam step_t STEP_TAG  = 3'd0;
  localparam step_t STEP_ID2  = 3'd1;
  localparam step_t STEP_ID1  = 3'd2;
  localparam step_t STEP_ID0  = 3'd3;
  localparam step_t STEP_LEN  = 3'd4;
  localparam step_t STEP_HI   = 3'd5;
  localparam step_t STEP_LO   = 3'd6;
  localparam step_t STEP_CR   = 3'd7;

  typedef struct packed {
    logic [10:0] ident;
    logic [3:0]  length_code;
    logic        is_extended;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
  } out_word_t;

  typedef enum logic [2:0] {
    SRC_TAG,
    SRC_ID2,
    SRC_ID1,
    SRC_ID0,
    SRC_LEN,
    SRC_HI,
    SRC_LO,
    SRC_CR
  } src_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_END
  } seq_t;

  typedef struct packed {
    src_t  src;
    logic  last;
    logic  inc;
    seq_t  seq;
    step_t target;
  } ctrl_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CHAR_0 + {4'b0000, d};
    end else begin
      r = CHAR_A + {4'b0000, d} - 8'd10;
    end
    return r;
  endfunction

  // SEQ_LOOP goes to the carriage return once all data bytes are out, else to target.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    case (s)
      STEP_TAG: c = '{src: SRC_TAG, last: 1'b0, inc: 1'b0, seq: SEQ_NEXT, target: STEP_TAG};
      STEP_ID2: c = '{src: SRC_ID2, last: 1'b0, inc: 1'b0, seq: SEQ_NEXT, target: STEP_TAG};
      STEP_ID1: c = '{src: SRC_ID1, last: 1'b0, inc: 1'b0, seq: SEQ_NEXT, target: STEP_TAG};
      STEP_ID0: c = '{src: SRC_ID0, last: 1'b0, inc: 1'b0, seq: SEQ_NEXT, target: STEP_TAG};
      STEP_LEN: c = '{src: SRC_LEN, last: 1'b0, inc: 1'b0, seq: SEQ_LOOP, target: STEP_HI};
      STEP_HI:  c = '{src: SRC_HI,  last: 1'b0, inc: 1'b0, seq: SEQ_NEXT, target: STEP_TAG};
      STEP_LO:  c = '{src: SRC_LO,  last: 1'b0, inc: 1'b1, seq: SEQ_LOOP, target: STEP_HI};
      STEP_CR:  c = '{src: SRC_CR,  last: 1'b1, inc: 1'b0, seq: SEQ_END,  target: STEP_TAG};
      default:  c = '{src: SRC_CR,  last: 1'b1, inc: 1'b0, seq: SEQ_END,  target: STEP_TAG};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/can_frame_to_slcan_ascii_unit.sv
// Top level of the CAN frame to SLCAN line encoder: a microcoded sequencer and its datapath.
// Depends on cf2sa_pkg for word types, constants and the microcode table.
//
// Channel   Direction  Word          Handshake
// in_       input      in_word_t     in_valid / in_ready
// out_      output     out_word_t    out_valid / out_ready
//
// A standard frame gives 6 + 2 * min(length_code, 8) characters, 6 to 22, one per cycle
// out of the step counter walking the microcode table while out_ready does not stall it.
// An extended frame is taken and dropped, and gives no word.
// A new frame is taken once the previous line's last character sits in the output register.
// A stall on out_ready holds the sequencer; rst_n, sampled synchronously, clears it to idle.
module can_frame_to_slcan_ascii_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cf2sa_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cf2sa_pkg::out_word_t out_data
);
  import cf2sa_pkg::*;

  logic        busy_r, busy_nxt;
  step_t       pc_r, pc_nxt;
  len_t        idx_r, idx_nxt;
  logic [10:0] ident_r;
  len_t        len_r;
  logic [7:0]  payload_r [MAX_DATA];
  logic        out_valid_r;
  out_word_t   out_data_r;

  ctrl_t       ctrl;
  logic        advance;
  logic        take;
  logic        done;
  len_t        idx_after;
  len_t        len_sat;
  logic [7:0]  cur_byte;
  logic [7:0]  char_val;

  assign in_ready  = !busy_r;
  assign take      = in_valid && in_ready;
  assign advance   = busy_r && (!out_valid_r || out_ready);
  assign ctrl      = ucode(pc_r);
  assign idx_after = ctrl.inc ? idx_r + 4'd1 : idx_r;
  assign done      = (idx_after == len_r);
  assign len_sat   = (in_data.length_code > LEN_MAX) ? LEN_MAX : in_data.length_code;
  assign cur_byte  = payload_r[idx_r[2:0]];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (ctrl.src)
      SRC_TAG: char_val = CHAR_T;
      SRC_ID2: char_val = hex_digit({1'b0, ident_r[10:8]});
      SRC_ID1: char_val = hex_digit(ident_r[7:4]);
      SRC_ID0: char_val = hex_digit(ident_r[3:0]);
      SRC_LEN: char_val = CHAR_0 + {4'b0000, len_r};
      SRC_HI:  char_val = hex_digit(cur_byte[7:4]);
      SRC_LO:  char_val = hex_digit(cur_byte[3:0]);
      SRC_CR:  char_val = CHAR_CR;
      default: char_val = CHAR_CR;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    idx_nxt  = idx_r;
    if (take) begin
      busy_nxt = !in_data.is_extended;
      pc_nxt   = STEP_TAG;
      idx_nxt  = '0;
    end else if (advance) begin
      idx_nxt = idx_after;
      case (ctrl.seq)
        SEQ_NEXT: pc_nxt = pc_r + 3'd1;
        SEQ_LOOP: pc_nxt = done ? STEP_CR : ctrl.target;
        SEQ_END:  busy_nxt = 1'b0;
        default:  busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= STEP_TAG;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      idx_r  <= idx_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !in_data.is_extended) begin
      ident_r      <= in_data.ident;
      len_r        <= len_sat;
      payload_r[0] <= in_data.byte0;
      payload_r[1] <= in_data.byte1;
      payload_r[2] <= in_data.byte2;
      payload_r[3] <= in_data.byte3;
      payload_r[4] <= in_data.byte4;
      payload_r[5] <= in_data.byte5;
      payload_r[6] <= in_data.byte6;
      payload_r[7] <= in_data.byte7;
    end
    if (advance) begin
      out_data_r.out_char <= char_val;
      out_data_r.line_end <= ctrl.last;
    end
  end

  a_line_end_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.line_end |-> out_data_r.out_char == CHAR_CR)
    else $error("line end flag on a character other than carriage return");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= len_r)
    else $error("byte index ran past the frame length");

  a_cr_after_all_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pc_r == STEP_CR |-> idx_r == len_r)
    else $error("carriage return reached before all data bytes");

  a_start_at_tag: assert property (@(posedge clk) disable iff (!rst_n)
    take && !in_data.is_extended |=> busy_r && pc_r == STEP_TAG && idx_r == '0)
    else $error("sequencer did not start a new line at its first step");

endmodule

// File: sim/slcan_line_checker.sv
// Checker for the CAN frame to SLCAN line encoder: watches both channels, builds the
// expected text line of every accepted standard frame and compares it word by word.
// Depends on cf2sa_pkg for the word types and ASCII constants.
module slcan_line_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  cf2sa_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  cf2sa_pkg::out_word_t out_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cf2sa_pkg::*;

  out_word_t line_chars[$];

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    return (nib < 4'd10) ? CHAR_0 + 8'(nib) : CHAR_A + 8'(nib) - 8'd10;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last);
    out_word_t w;
    w.out_char = c;
    w.line_end = last;
    line_chars.push_back(w);
  endtask

  task automatic queue_line(input in_word_t f);
    logic [7:0] data_bytes [MAX_DATA];
    logic [3:0] n;
    data_bytes = '{f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7};
    n = (f.length_code > LEN_MAX) ? LEN_MAX : f.length_code;
    push_char(CHAR_T, 1'b0);
    push_char(ascii_hex({1'b0, f.ident[10:8]}), 1'b0);
    push_char(ascii_hex(f.ident[7:4]), 1'b0);
    push_char(ascii_hex(f.ident[3:0]), 1'b0);
    push_char(CHAR_0 + {4'b0000, n}, 1'b0);
    for (int i = 0; i < n; i++) begin
      push_char(ascii_hex(data_bytes[i][7:4]), 1'b0);
      push_char(ascii_hex(data_bytes[i][3:0]), 1'b0);
    end
    push_char(CHAR_CR, 1'b1);
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      line_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (line_chars.size() == 0) begin
          $display("%0t: unexpected word char=%h line_end=%b",
                   $time, out_data.out_char, out_data.line_end);
          fail_count++;
        end else begin
          want = line_chars.pop_front();
          if (want.out_char !== out_data.out_char || want.line_end !== out_data.line_end) begin
            $display("%0t: mismatch expected char=%h line_end=%b, actual char=%h line_end=%b",
                     $time, want.out_char, want.line_end, out_data.out_char, out_data.line_end);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready && !in_data.is_extended) begin
        queue_line(in_data);
      end
    end
    pending = line_chars.size();
  end

endmodule

// File: sim/tb_can_frame_to_slcan_ascii_unit.sv
// Testbench top for the CAN frame to SLCAN line encoder: drives directed and random frames
// with random idling on both channels and gives the verdict.
// Depends on cf2sa_pkg, can_frame_to_slcan_ascii_unit and slcan_line_checker.
module tb_can_frame_to_slcan_ascii_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cf2sa_pkg::*;

  localparam int RANDOM_FRAMES = 258;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  bit        calm = 1'b0;
  int        sent;
  in_word_t  f;

  always #1 clk = ~clk;

  can_frame_to_slcan_ascii_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  slcan_line_checker line_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 19);
    if (r < 8) begin
      return 0;
    end else if (r < 16) begin
      return $urandom_range(1, 3);
    end else if (r < 19) begin
      return $urandom_range(4, 9);
    end
    return $urandom_range(15, 40);
  endfunction

  function automatic in_word_t make_frame(input logic [10:0] ident, input logic [3:0] code,
                                          input logic ext, input logic [7:0] seed);
    in_word_t w;
    w.ident       = ident;
    w.length_code = code;
    w.is_extended = ext;
    w.byte0       = seed;
    w.byte1       = seed ^ 8'h11;
    w.byte2       = seed ^ 8'h22;
    w.byte3       = seed ^ 8'h33;
    w.byte4       = seed ^ 8'h44;
    w.byte5       = seed ^ 8'h55;
    w.byte6       = seed ^ 8'h66;
    w.byte7       = seed ^ 8'h77;
    return w;
  endfunction

  function automatic in_word_t rand_frame();
    in_word_t w;
    w.ident       = 11'($urandom_range(0, 2047));
    w.length_code = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
    w.is_extended = ($urandom_range(0, 6) == 0);
    w.byte0       = 8'($urandom);
    w.byte1       = 8'($urandom);
    w.byte2       = 8'($urandom);
    w.byte3       = 8'($urandom);
    w.byte4       = 8'($urandom);
    w.byte5       = 8'($urandom);
    w.byte6       = 8'($urandom);
    w.byte7       = 8'($urandom);
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_frame(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : sink_pacing
    int hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_frame(make_frame(11'h000, 4'd0, 1'b0, 8'h00));
    send_frame(make_frame(11'h7FF, 4'd8, 1'b0, 8'hFF));
    for (int len = 0; len < 16; len++) begin
      send_frame(make_frame(11'(len * 137 + 5), 4'(len), 1'b0, 8'(len * 8'h1B + 8'h8C)));
    end
    send_frame(make_frame(11'h5A5, 4'd8, 1'b1, 8'hA5));
    send_frame(make_frame(11'h7FF, 4'd15, 1'b1, 8'hFF));
    send_frame(make_frame(11'h123, 4'd3, 1'b0, 8'h9E));
    send_frame(make_frame(11'h7FF, 4'd15, 1'b0, 8'hFF));

    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      if (sent % 40 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      f = rand_frame();
      send_frame(f);
      sent++;
    end
    in_valid = 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cf2sa_pkg.sv
rtl/core/can_frame_to_slcan_ascii_unit.sv
sim/slcan_line_checker.sv
sim/tb_can_frame_to_slcan_ascii_unit.sv
